// ----- rtl/i2cm_pkg.sv -----
// Shared types, constants and helpers for the I2C master transaction engine.
package i2cm_pkg;

    localparam int WRITE_DEPTH = 16;
    localparam int FILL_W      = $clog2(WRITE_DEPTH + 1);
    localparam int IDX_W       = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
    localparam int WLEN_W      = 5;
    localparam int RLEN_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int BITCNT_W    = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] ADDR_DIR_BIT = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_MSB     = 8'h80;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_LOAD,
        CMD_START
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_SEND_BITS,
        PH_SEND_ACK,
        PH_RECV_BITS,
        PH_RECV_ACK,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        STG_ADDR1,
        STG_WDATA,
        STG_ADDR2
    } stage_t;

    typedef struct packed {
        kind_t               kind;
        logic                is_read;
        logic                sda_in;
        logic [BYTE_W-1:0]   data_byte;
        logic [BYTE_W-1:0]   address;
        logic [FILL_W-1:0]   write_total;
        logic [RLEN_W-1:0]   recv_count;
    } cmd_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_listening;
        logic              busy_res;
        logic              read_valid;
        logic [BYTE_W-1:0] read_data;
        logic              read_last;
        logic              done_res;
        logic              success;
    } res_t;

    function automatic logic [FILL_W-1:0] sat_wlen(input logic [WLEN_W-1:0] wlen);
        logic [FILL_W-1:0] r;
        if (int'(wlen) > WRITE_DEPTH)
            r = FILL_W'(WRITE_DEPTH);
        else
            r = FILL_W'(wlen);
        return r;
    endfunction

endpackage

// ----- rtl/i2c_master_transaction_engine_unit.sv -----
// Top level of the I2C master transaction engine: front end, command queue, bus sequencer.
//
// Usage: each input transaction on s_axis is one bus tick (one delay interval).
// s_axis_tuser carries the operation (tick, load write byte, start write, start read);
// s_axis_tdata carries the SDA sample, data byte, device address and lengths.
// Every input transaction yields exactly one output transaction on m_axis with the SCL
// and SDA levels for that tick plus busy, received byte and done/success status;
// m_axis_tlast marks the final received byte of a read.
// Throughput: one tick per clock cycle while m_axis accepts results; a stalled m_axis holds the sequencer.
// With the queue empty, an accepted input is first stored in the queue and is then
// sequenced into the output register.
// A two-entry queue decouples input from the sequencer; when m_axis stalls the
// sequencer holds and the queue fills, then s_axis_tready drops.
// Write bytes are loaded while idle; a write to a full buffer is ignored.
// Reset returns the bus to idle (SCL and SDA released), empties the queue and clears
// the buffer fill count; the buffer contents are kept.
module i2c_master_transaction_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] sda_in, [8:1] data_byte, [16:9] device_address, [21:17] send_count,
    // [37:22] recv_count, [39:38] zero
    input  logic [39:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] sda_listening, [3] busy_res, [4] read_valid,
    // [12:5] read_data, [13] done_res, [14] success, [15] zero
    output logic [15:0] m_axis_tdata,
    // read_last
    output logic        m_axis_tlast
);

    i2cm_pkg::cmd_t push_cmd;
    i2cm_pkg::cmd_t head_cmd;
    i2cm_pkg::res_t res;
    logic           q_ready;
    logic           q_push;
    logic           q_valid;
    logic           q_pop;

    i2cm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    i2cm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_cmd (head_cmd)
    );

    i2cm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {1'b0, res.success, res.done_res, res.read_data, res.read_valid,
                           res.busy_res, res.sda_listening, res.sda_level, res.scl_level};
    assign m_axis_tlast = res.read_last;

endmodule

// ----- rtl/i2cm_front.sv -----
// Front end: takes input transactions, decodes the operation and queues a command.
module i2cm_front (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [39:0]         s_axis_tdata,
    input  logic [1:0]          s_axis_tuser,
    input  logic                q_ready,
    output logic                q_push,
    output i2cm_pkg::cmd_t      q_cmd
);

    logic [i2cm_pkg::BYTE_W-1:0] addr;

    assign s_axis_tready = q_ready;
    assign q_push        = s_axis_tvalid & q_ready;
    assign addr          = s_axis_tdata[16:9];

    always_comb
    begin
        q_cmd             = '0;
        q_cmd.sda_in      = s_axis_tdata[0];
        q_cmd.data_byte   = s_axis_tdata[8:1];
        q_cmd.write_total = i2cm_pkg::sat_wlen(s_axis_tdata[21:17]);
        q_cmd.recv_count  = s_axis_tdata[37:22];
        q_cmd.address     = addr;
        q_cmd.kind        = i2cm_pkg::CMD_TICK;
        q_cmd.is_read     = 1'b0;
        case (i2cm_pkg::op_t'(s_axis_tuser))
            i2cm_pkg::OP_LOAD:
            begin
                q_cmd.kind = i2cm_pkg::CMD_LOAD;
            end
            i2cm_pkg::OP_WRITE:
            begin
                q_cmd.kind = i2cm_pkg::CMD_START;
            end
            i2cm_pkg::OP_READ:
            begin
                q_cmd.kind    = i2cm_pkg::CMD_START;
                q_cmd.is_read = 1'b1;
                q_cmd.address = addr & ~i2cm_pkg::ADDR_DIR_BIT;
            end
            default:
            begin
                q_cmd.kind = i2cm_pkg::CMD_TICK;
            end
        endcase
    end

endmodule

// ----- rtl/i2cm_queue.sv -----
// Short command queue between front end and bus sequencer.
module i2cm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  i2cm_pkg::cmd_t push_cmd,
    output logic           ready,
    input  logic           pop,
    output logic           valid,
    output i2cm_pkg::cmd_t head_cmd
);

    i2cm_pkg::cmd_t                   entry_reg [i2cm_pkg::QUEUE_DEPTH];
    logic [i2cm_pkg::QPTR_W-1:0]      wptr_reg, wptr_next;
    logic [i2cm_pkg::QPTR_W-1:0]      rptr_reg, rptr_next;
    logic [i2cm_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign ready    = count_reg != i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH);
    assign valid    = count_reg != '0;
    assign head_cmd = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
            wptr_next = wptr_reg + 1'b1;
        if (pop)
            rptr_next = rptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_cmd;
    end

endmodule

// ----- rtl/i2cm_back.sv -----
// Bus sequencer: one tick per command, drives SCL/SDA and registers the result.
module i2cm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  i2cm_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output i2cm_pkg::res_t out_res
);

    localparam int FW = i2cm_pkg::FILL_W;
    localparam int RW = i2cm_pkg::RLEN_W;
    localparam int BW = i2cm_pkg::BYTE_W;

    i2cm_pkg::phase_t               phase_reg, phase_next, phase_eff;
    i2cm_pkg::stage_t               stage_reg, stage_next, stage_eff;
    logic [1:0]                     sub_reg, sub_next, sub_eff;
    logic [BW-1:0]                  shift_reg, shift_next, shift_eff;
    logic [i2cm_pkg::BITCNT_W-1:0]  bit_reg, bit_next;
    logic [RW-1:0]                  bcount_reg, bcount_next;
    logic [FW-1:0]                  fill_reg, fill_next;
    logic [FW-1:0]                  wtotal_reg, wtotal_next;
    logic [RW-1:0]                  rtotal_reg, rtotal_next;
    logic [BW-1:0]                  addr_reg, addr_next;
    logic                           rmode_reg, rmode_next;
    logic                           failed_reg, failed_next;
    logic                           latch_reg, latch_next;
    logic [BW-1:0]                  wbuf_reg [i2cm_pkg::WRITE_DEPTH];
    logic                           wbuf_we;
    logic                           out_valid_reg;
    i2cm_pkg::res_t                 out_res_reg, res;

    logic                           step;
    logic                           is_idle;
    logic                           last;
    logic [RW-1:0]                  next_idx;
    logic [BW-1:0]                  wbuf_rd;

    assign step      = q_valid & (~out_valid_reg | out_ready);
    assign q_pop     = step;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign is_idle   = phase_reg == i2cm_pkg::PH_IDLE;
    assign last      = ({1'b0, bcount_reg} + (RW + 1)'(1)) >= {1'b0, rtotal_reg};
    assign next_idx  = (stage_reg == i2cm_pkg::STG_ADDR1) ? '0 : bcount_reg + 1'b1;
    assign wbuf_rd   = wbuf_reg[next_idx[i2cm_pkg::IDX_W-1:0]];
    assign wbuf_we   = step && is_idle && q_cmd.kind == i2cm_pkg::CMD_LOAD
                       && fill_reg != FW'(i2cm_pkg::WRITE_DEPTH);

    // Idle-time command handling: a start turns this tick into the first start tick.
    always_comb
    begin
        phase_eff   = phase_reg;
        stage_eff   = stage_reg;
        sub_eff     = sub_reg;
        shift_eff   = shift_reg;
        fill_next   = fill_reg;
        wtotal_next = wtotal_reg;
        rtotal_next = rtotal_reg;
        addr_next   = addr_reg;
        rmode_next  = rmode_reg;
        if (is_idle)
        begin
            case (q_cmd.kind)
                i2cm_pkg::CMD_LOAD:
                begin
                    if (fill_reg != FW'(i2cm_pkg::WRITE_DEPTH))
                        fill_next = fill_reg + 1'b1;
                end
                i2cm_pkg::CMD_START:
                begin
                    rmode_next  = q_cmd.is_read;
                    wtotal_next = q_cmd.write_total;
                    rtotal_next = q_cmd.recv_count;
                    addr_next   = q_cmd.address;
                    fill_next   = '0;
                    phase_eff   = i2cm_pkg::PH_START;
                    sub_eff     = 2'd0;
                    shift_eff   = q_cmd.address;
                    stage_eff   = i2cm_pkg::STG_ADDR1;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    // Next state of the sequencer.
    always_comb
    begin
        phase_next  = phase_eff;
        stage_next  = stage_eff;
        sub_next    = sub_eff;
        shift_next  = shift_eff;
        bit_next    = bit_reg;
        bcount_next = bcount_reg;
        failed_next = failed_reg;
        latch_next  = latch_reg;
        if (is_idle && q_cmd.kind == i2cm_pkg::CMD_START)
        begin
            failed_next = 1'b0;
            bcount_next = '0;
        end
        case (phase_eff)
            i2cm_pkg::PH_START:
            begin
                latch_next = (sub_eff == 2'd0);
                if (sub_eff >= 2'd2)
                begin
                    phase_next = i2cm_pkg::PH_SEND_BITS;
                    sub_next   = 2'd0;
                    bit_next   = '0;
                end
                else
                begin
                    sub_next = sub_eff + 2'd1;
                end
            end
            i2cm_pkg::PH_SEND_BITS:
            begin
                if (sub_eff == 2'd0)
                begin
                    sub_next = 2'd1;
                end
                else if (sub_eff == 2'd1)
                begin
                    latch_next = |(shift_eff & i2cm_pkg::BYTE_MSB);
                    sub_next   = 2'd2;
                end
                else
                begin
                    shift_next = {shift_eff[BW-2:0], 1'b0};
                    sub_next   = 2'd0;
                    bit_next   = bit_reg + 1'b1;
                    if (&bit_reg)
                        phase_next = i2cm_pkg::PH_SEND_ACK;
                end
            end
            i2cm_pkg::PH_SEND_ACK:
            begin
                if (sub_eff == 2'd0)
                begin
                    sub_next = 2'd1;
                end
                else
                begin
                    sub_next = 2'd0;
                    if (q_cmd.sda_in)
                    begin
                        failed_next = 1'b1;
                        phase_next  = i2cm_pkg::PH_STOP;
                    end
                    else if (stage_eff == i2cm_pkg::STG_ADDR2)
                    begin
                        if (rtotal_reg != '0)
                        begin
                            phase_next  = i2cm_pkg::PH_RECV_BITS;
                            bit_next    = '0;
                            bcount_next = '0;
                            shift_next  = '0;
                        end
                        else
                        begin
                            phase_next = i2cm_pkg::PH_STOP;
                        end
                    end
                    else
                    begin
                        bcount_next = next_idx;
                        if (next_idx < RW'(wtotal_reg))
                        begin
                            phase_next = i2cm_pkg::PH_SEND_BITS;
                            bit_next   = '0;
                            shift_next = wbuf_rd;
                            stage_next = i2cm_pkg::STG_WDATA;
                        end
                        else if (rmode_reg)
                        begin
                            phase_next = i2cm_pkg::PH_START;
                            shift_next = addr_reg | i2cm_pkg::ADDR_DIR_BIT;
                            stage_next = i2cm_pkg::STG_ADDR2;
                        end
                        else
                        begin
                            phase_next = i2cm_pkg::PH_STOP;
                        end
                    end
                end
            end
            i2cm_pkg::PH_RECV_BITS:
            begin
                if (sub_eff == 2'd0)
                begin
                    shift_next = {shift_eff[BW-2:0], q_cmd.sda_in};
                    sub_next   = 2'd1;
                end
                else
                begin
                    sub_next = 2'd0;
                    bit_next = bit_reg + 1'b1;
                    if (&bit_reg)
                        phase_next = i2cm_pkg::PH_RECV_ACK;
                end
            end
            i2cm_pkg::PH_RECV_ACK:
            begin
                latch_next = last;
                if (sub_eff == 2'd0)
                begin
                    sub_next = 2'd1;
                end
                else
                begin
                    latch_next  = 1'b1;
                    bcount_next = bcount_reg + 1'b1;
                    sub_next    = 2'd0;
                    shift_next  = '0;
                    phase_next  = last ? i2cm_pkg::PH_STOP : i2cm_pkg::PH_RECV_BITS;
                end
            end
            i2cm_pkg::PH_STOP:
            begin
                if (sub_eff == 2'd0)
                begin
                    latch_next = 1'b0;
                    sub_next   = 2'd1;
                end
                else if (sub_eff == 2'd1)
                begin
                    latch_next = 1'b0;
                    sub_next   = 2'd2;
                end
                else
                begin
                    latch_next = 1'b1;
                    phase_next = i2cm_pkg::PH_IDLE;
                    sub_next   = 2'd0;
                end
            end
            default:
            begin
                phase_next = i2cm_pkg::PH_IDLE;
            end
        endcase
    end

    // Pin levels and status for this tick.
    always_comb
    begin
        res           = '0;
        res.scl_level = 1'b1;
        res.sda_level = 1'b1;
        case (phase_eff)
            i2cm_pkg::PH_START:
            begin
                res.busy_res  = 1'b1;
                res.sda_level = (sub_eff == 2'd0);
                res.scl_level = (sub_eff < 2'd2);
            end
            i2cm_pkg::PH_SEND_BITS:
            begin
                res.busy_res  = 1'b1;
                res.scl_level = (sub_eff >= 2'd2);
                res.sda_level = (sub_eff == 2'd1) ? |(shift_eff & i2cm_pkg::BYTE_MSB)
                                                  : latch_reg;
            end
            i2cm_pkg::PH_SEND_ACK:
            begin
                res.busy_res      = 1'b1;
                res.sda_listening = 1'b1;
                res.scl_level     = (sub_eff != 2'd0);
            end
            i2cm_pkg::PH_RECV_BITS:
            begin
                res.busy_res      = 1'b1;
                res.sda_listening = 1'b1;
                res.scl_level     = (sub_eff == 2'd0);
            end
            i2cm_pkg::PH_RECV_ACK:
            begin
                res.busy_res   = 1'b1;
                res.sda_level  = last;
                res.scl_level  = (sub_eff == 2'd0);
                res.read_valid = (sub_eff == 2'd0);
                res.read_data  = (sub_eff == 2'd0) ? shift_eff : '0;
                res.read_last  = (sub_eff == 2'd0) & last;
            end
            i2cm_pkg::PH_STOP:
            begin
                res.busy_res  = 1'b1;
                res.scl_level = (sub_eff != 2'd0);
                res.sda_level = (sub_eff >= 2'd2);
                res.done_res  = (sub_eff >= 2'd2);
                res.success   = (sub_eff >= 2'd2) & ~failed_reg;
            end
            default:
            begin
                res.scl_level = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cm_pkg::PH_IDLE;
            stage_reg     <= i2cm_pkg::STG_ADDR1;
            sub_reg       <= '0;
            shift_reg     <= '0;
            bit_reg       <= '0;
            bcount_reg    <= '0;
            fill_reg      <= '0;
            wtotal_reg    <= '0;
            rtotal_reg    <= '0;
            addr_reg      <= '0;
            rmode_reg     <= 1'b0;
            failed_reg    <= 1'b0;
            latch_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg  <= phase_next;
                stage_reg  <= stage_next;
                sub_reg    <= sub_next;
                shift_reg  <= shift_next;
                bit_reg    <= bit_next;
                bcount_reg <= bcount_next;
                fill_reg   <= fill_next;
                wtotal_reg <= wtotal_next;
                rtotal_reg <= rtotal_next;
                addr_reg   <= addr_next;
                rmode_reg  <= rmode_next;
                failed_reg <= failed_next;
                latch_reg  <= latch_next;
            end
            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_res_reg <= res;
        if (wbuf_we)
            wbuf_reg[fill_reg[i2cm_pkg::IDX_W-1:0]] <= q_cmd.data_byte;
    end

endmodule
